FILE: sv/cjsu_pkg.sv
// ============================================================================
// cjsu_pkg
// shared types and constants of the string unescaper: request and result
// layouts, the command passed from the parser to the result sequencer
// ============================================================================
package cjsu_pkg;

    // source buffer length limit, offsets saturate below it
    localparam longint MAX_LENGTH = 65536;
    localparam longint POS_LIMIT  = (MAX_LENGTH < 65535) ? MAX_LENGTH : 65535;
    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_LIMIT);

    // command queue between parser and sequencer
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    // most bytes one request can emit before its final result
    localparam int MAX_BYTES = 4;
    localparam int NB_W      = $clog2(MAX_BYTES + 1);

    // final status codes
    localparam logic [2:0] ST_END       = 3'd0;
    localparam logic [2:0] ST_QUOTE     = 3'd1;
    localparam logic [2:0] ST_BAD_ESC   = 3'd2;
    localparam logic [2:0] ST_LONE_LEAD = 3'd3;
    localparam logic [2:0] ST_LONE_TAIL = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_present;
        logic       end_of_buffer;
    } item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_valid;
        logic             done_res;
        logic [2:0]       status;
        logic [POS_W-1:0] stop_offset;
        logic             last;
    } result_t;

    // everything one request produces: up to four bytes, then maybe a final
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [NB_W-1:0]           nbytes;
        logic                      has_final;
        logic [2:0]                status;
        logic [POS_W-1:0]          offset;
    } cmd_t;

endpackage

FILE: sv/cjsu_front.sv
// ============================================================================
// cjsu_front
// escape parser: takes one source byte per request and turns it into a
// command holding the bytes and the final status that it causes
// ============================================================================
module cjsu_front
    import cjsu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item,
    output logic  cmd_valid,
    output cmd_t  cmd
);

    typedef enum logic [8:0] {
        PH_PLAIN   = 9'b000000001,
        PH_ESC     = 9'b000000010,
        PH_HEX2    = 9'b000000100,
        PH_OCT     = 9'b000001000,
        PH_U4      = 9'b000010000,
        PH_U8      = 9'b000100000,
        PH_LEAD_BS = 9'b001000000,
        PH_LEAD_U  = 9'b010000000,
        PH_TAIL4   = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [NB_W-1:0]           n;
    } utf8_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] CH_U_HI   = 8'h55;

    // single-letter escapes, zero when the letter is not one
    function automatic logic [7:0] single_letter(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h5C:   r = 8'h5C;
            8'h22:   r = 8'h22;
            8'h27:   r = 8'h27;
            8'h2F:   r = 8'h2F;
            8'h61:   r = 8'h07;
            8'h62:   r = 8'h08;
            8'h65:   r = 8'h1B;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h76:   r = 8'h0B;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // bit 4 set for a hex digit, low nibble its value
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t u;
        u = '0;
        if (cp < 21'h80) begin
            u.bytes[0] = cp[7:0];
            u.n        = NB_W'(1);
        end
        else if (cp < 21'h800) begin
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
            u.n        = NB_W'(2);
        end
        else if (cp < 21'h10000) begin
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
            u.n        = NB_W'(3);
        end
        else begin
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
            u.n        = NB_W'(4);
        end
        return u;
    endfunction

    phase_t           phase_reg, phase_next;
    logic [31:0]      acc_reg, acc_next;
    logic [3:0]       digits_reg, digits_next;
    logic [9:0]       lead_reg, lead_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] esc_reg, esc_next;
    logic             fin_reg, fin_next;

    logic [7:0]  b;
    logic [7:0]  letter;
    logic [4:0]  hv;
    logic [3:0]  dig_inc;
    logic [31:0] acc_hex;
    logic [31:0] acc_oct;
    logic        is_oct;
    logic        do_plain;
    logic        do_utf8;
    logic [20:0] cp;
    utf8_t       enc;

    assign b       = item.in_byte;
    assign letter  = single_letter(b);
    assign hv      = hex_value(b);
    assign dig_inc = digits_reg + 4'd1;
    assign acc_hex = {acc_reg[27:0], hv[3:0]};
    assign acc_oct = {acc_reg[28:0], b[2:0]};
    assign is_oct  = (b >= 8'h30) && (b <= 8'h37);

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        lead_next   = lead_reg;
        pos_next    = pos_reg;
        esc_next    = esc_reg;
        fin_next    = fin_reg;
        cmd         = '0;
        do_plain    = 1'b0;
        do_utf8     = 1'b0;
        cp          = '0;
        enc         = '0;

        if (accept && item.byte_present) begin
            if (!fin_reg) begin
                unique case (phase_reg) inside
                    PH_ESC:
                    begin
                        if (letter != 8'h00) begin
                            cmd.bytes[0] = letter;
                            cmd.nbytes   = NB_W'(1);
                            phase_next   = PH_PLAIN;
                        end
                        else if (b == CH_X || b == CH_U_LO || b == CH_U_HI) begin
                            phase_next  = (b == CH_X) ? PH_HEX2 :
                                          (b == CH_U_LO) ? PH_U4 : PH_U8;
                            acc_next    = '0;
                            digits_next = '0;
                        end
                        else if (is_oct) begin
                            phase_next  = PH_OCT;
                            acc_next    = {29'd0, b[2:0]};
                            digits_next = 4'd1;
                        end
                        else begin
                            cmd.has_final = 1'b1;
                            cmd.status    = ST_BAD_ESC;
                            cmd.offset    = esc_reg;
                            fin_next      = 1'b1;
                            phase_next    = PH_PLAIN;
                        end
                    end
                    PH_OCT:
                    begin
                        if (is_oct && (digits_reg == 4'd1 || acc_reg < 32'd32)) begin
                            acc_next    = acc_oct;
                            digits_next = dig_inc;
                            if (dig_inc >= 4'd3 || acc_oct >= 32'd32) begin
                                cmd.bytes[0] = acc_oct[7:0];
                                cmd.nbytes   = NB_W'(1);
                                phase_next   = PH_PLAIN;
                            end
                        end
                        else begin
                            // octal ended early: value first, then the byte as plain
                            cmd.bytes[0] = acc_reg[7:0];
                            cmd.nbytes   = NB_W'(1);
                            phase_next   = PH_PLAIN;
                            do_plain     = 1'b1;
                        end
                    end
                    PH_HEX2, PH_U4, PH_U8, PH_TAIL4:
                    begin
                        if (!hv[4]) begin
                            cmd.has_final = 1'b1;
                            cmd.status    = (phase_reg == PH_TAIL4) ? ST_LONE_LEAD : ST_BAD_ESC;
                            cmd.offset    = esc_reg;
                            fin_next      = 1'b1;
                            phase_next    = PH_PLAIN;
                        end
                        else begin
                            acc_next    = acc_hex;
                            digits_next = dig_inc;
                            if (phase_reg == PH_HEX2 && dig_inc == 4'd2) begin
                                cmd.bytes[0] = acc_hex[7:0];
                                cmd.nbytes   = NB_W'(1);
                                phase_next   = PH_PLAIN;
                            end
                            else if (phase_reg == PH_U8 && dig_inc == 4'd8) begin
                                if (acc_hex > 32'h0010FFFF) begin
                                    cmd.has_final = 1'b1;
                                    cmd.status    = ST_RANGE;
                                    cmd.offset    = esc_reg;
                                    fin_next      = 1'b1;
                                end
                                else begin
                                    cp      = acc_hex[20:0];
                                    do_utf8 = 1'b1;
                                end
                                phase_next = PH_PLAIN;
                            end
                            else if (phase_reg == PH_U4 && dig_inc == 4'd4) begin
                                if (acc_hex[15:10] == 6'b110110) begin
                                    lead_next  = acc_hex[9:0];
                                    phase_next = PH_LEAD_BS;
                                end
                                else if (acc_hex[15:10] == 6'b110111) begin
                                    cmd.has_final = 1'b1;
                                    cmd.status    = ST_LONE_TAIL;
                                    cmd.offset    = esc_reg;
                                    fin_next      = 1'b1;
                                    phase_next    = PH_PLAIN;
                                end
                                else begin
                                    cp         = {5'd0, acc_hex[15:0]};
                                    do_utf8    = 1'b1;
                                    phase_next = PH_PLAIN;
                                end
                            end
                            else if (phase_reg == PH_TAIL4 && dig_inc == 4'd4) begin
                                if (acc_hex[15:10] == 6'b110111) begin
                                    // 0x10000 plus the pair's 20 bits
                                    cp      = {11'({1'b0, lead_reg}) + 11'd64, acc_hex[9:0]};
                                    do_utf8 = 1'b1;
                                end
                                else begin
                                    cmd.has_final = 1'b1;
                                    cmd.status    = ST_LONE_LEAD;
                                    cmd.offset    = esc_reg;
                                    fin_next      = 1'b1;
                                end
                                phase_next = PH_PLAIN;
                            end
                        end
                    end
                    PH_LEAD_BS:
                    begin
                        if (b == CH_BSLASH) begin
                            phase_next = PH_LEAD_U;
                        end
                        else begin
                            cmd.has_final = 1'b1;
                            cmd.status    = ST_LONE_LEAD;
                            cmd.offset    = esc_reg;
                            fin_next      = 1'b1;
                            phase_next    = PH_PLAIN;
                        end
                    end
                    PH_LEAD_U:
                    begin
                        if (b == CH_U_LO) begin
                            phase_next  = PH_TAIL4;
                            acc_next    = '0;
                            digits_next = '0;
                        end
                        else begin
                            cmd.has_final = 1'b1;
                            cmd.status    = ST_LONE_LEAD;
                            cmd.offset    = esc_reg;
                            fin_next      = 1'b1;
                            phase_next    = PH_PLAIN;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_PLAIN;
                        do_plain   = 1'b1;
                    end
                endcase

                if (do_utf8) begin
                    enc        = utf8_encode(cp);
                    cmd.bytes  = enc.bytes;
                    cmd.nbytes = enc.n;
                end

                if (do_plain) begin
                    if (b == CH_QUOTE) begin
                        cmd.has_final = 1'b1;
                        cmd.status    = ST_QUOTE;
                        cmd.offset    = pos_reg;
                        fin_next      = 1'b1;
                        phase_next    = PH_PLAIN;
                    end
                    else if (b == CH_BSLASH) begin
                        esc_next   = pos_reg;
                        phase_next = PH_ESC;
                    end
                    else begin
                        cmd.bytes[cmd.nbytes[1:0]] = b;
                        cmd.nbytes = cmd.nbytes + NB_W'(1);
                    end
                end
            end
            if (pos_reg < POS_CAP) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end

        if (accept && item.end_of_buffer) begin
            if (!fin_next) begin
                cmd.has_final = 1'b1;
                if (phase_next == PH_PLAIN || phase_next == PH_OCT) begin
                    if (phase_next == PH_OCT) begin
                        cmd.bytes[cmd.nbytes[1:0]] = acc_next[7:0];
                        cmd.nbytes = cmd.nbytes + NB_W'(1);
                    end
                    cmd.status = ST_END;
                    cmd.offset = pos_next;
                end
                else if (phase_next == PH_LEAD_BS || phase_next == PH_LEAD_U ||
                         phase_next == PH_TAIL4) begin
                    cmd.status = ST_LONE_LEAD;
                    cmd.offset = esc_next;
                end
                else begin
                    cmd.status = ST_BAD_ESC;
                    cmd.offset = esc_next;
                end
            end
            // fresh state for the next buffer
            phase_next  = PH_PLAIN;
            acc_next    = '0;
            digits_next = '0;
            lead_next   = '0;
            pos_next    = '0;
            esc_next    = '0;
            fin_next    = 1'b0;
        end
    end

    assign cmd_valid = accept && (cmd.has_final || (cmd.nbytes != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_PLAIN;
            acc_reg    <= '0;
            digits_reg <= '0;
            lead_reg   <= '0;
            pos_reg    <= '0;
            esc_reg    <= '0;
            fin_reg    <= 1'b0;
        end
        else begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            lead_reg   <= lead_next;
            pos_reg    <= pos_next;
            esc_reg    <= esc_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

FILE: sv/cjsu_cmd_fifo.sv
// ============================================================================
// cjsu_cmd_fifo
// short command queue that decouples the parser from the result sequencer
// ============================================================================
module cjsu_cmd_fifo
    import cjsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd,
    input  logic rd_en
);

    cmd_t              mem_reg [CMD_DEPTH];
    logic [CMD_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_AW:0]   count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full       = (count_reg == (CMD_AW + 1)'(CMD_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + CMD_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + CMD_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (CMD_AW + 1)'(do_wr) - (CMD_AW + 1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/cjsu_back.sv
// ============================================================================
// cjsu_back
// result sequencer: walks the head command one result per cycle, while the
// output register is empty or popped, into the output register
// ============================================================================
module cjsu_back
    import cjsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  cmd_t    head_cmd,
    output logic    head_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    logic [NB_W-1:0] idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg;
    result_t         res;
    logic [NB_W-1:0] total;
    logic            is_byte;
    logic            load;

    assign total   = head_cmd.nbytes + NB_W'(head_cmd.has_final);
    assign is_byte = (idx_reg < head_cmd.nbytes);
    assign load    = head_valid && (!out_valid_reg || pop);

    always_comb
    begin
        res.out_byte    = is_byte ? head_cmd.bytes[idx_reg[1:0]] : 8'h00;
        res.out_valid   = is_byte;
        res.done_res    = !is_byte;
        res.status      = is_byte ? ST_END : head_cmd.status;
        res.stop_offset = is_byte ? '0 : head_cmd.offset;
        res.last        = ((idx_reg + NB_W'(1)) == total);
    end

    always_comb
    begin
        head_pop       = load && res.last;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            idx_next       = res.last ? '0 : idx_reg + NB_W'(1);
            out_valid_next = 1'b1;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

FILE: sv/c_json_string_unescaper_core.sv
// ============================================================================
// c_json_string_unescaper_core
// path: a request's results pass through the command queue, then the output register
// throughput: one request per cycle while each yields at most one result and
//   results are popped; the sequencer emits one result per cycle, so a request
//   with several results holds it and the four-entry command queue absorbs such bursts
// reset: rst_n clears the parser state, the command queue and the output
// ============================================================================
module c_json_string_unescaper_core
    import cjsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    // request side
    input  logic    push,
    output logic    full,
    input  item_t   item,
    // result side
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic accept;
    logic cmd_valid;
    cmd_t cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic head_pop;

    // a request is taken whenever the queue has room for its command
    assign accept = push && !full;

    // parser: decodes escapes, one source byte per cycle while the queue is not full
    cjsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // commands waiting for the sequencer; requests with no result skip it
    cjsu_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cmd_valid),
        .wr_cmd     (cmd),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .rd_en      (head_pop)
    );

    // sequencer: bytes first, then the final status, last flag on the end
    cjsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

FILE: sv/cjsu_checker.sv
// ============================================================================
// cjsu_checker
// port-level checks of the unescaper's result side
// ============================================================================
module cjsu_checker
    import cjsu_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");

    // more results of the same request follow without a gap
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last) |=> !empty)
        else $error("gap inside one request's results");

    // a full queue always has a result on show
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full with no result shown");

    // a final result closes its request and carries no byte
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.done_res) |-> (result.last && !result.out_valid))
        else $error("final result malformed");

endmodule

bind c_json_string_unescaper_core cjsu_checker u_checker (.*);
